// File: hdl/shared_buffer_multi_queue_core_macros.svh
// Assertion macros shared by the shared buffer multi queue RTL.
`ifndef SHARED_BUFFER_MULTI_QUEUE_CORE_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, inactive while arst_n is low.
`define SBMQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbmq assertion failed");

// Next-cycle implication, sampled on clk, inactive while arst_n is low.
`define SBMQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbmq assertion failed");

`endif

// File: hdl/sbmq_pkg.sv
// Package with sizes, codes and the command type of the shared buffer multi queue.
package sbmq_pkg;

	localparam int SLOTS  = 16;
	localparam int QUEUES = 4;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int LINK_W = $clog2(SLOTS + 1);
	localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int QID_W  = 2;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

endpackage

// File: hdl/sbmq_ctrl.sv
// Controller state machine that sequences each request through read and commit.
module sbmq_ctrl
	import sbmq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_ready,
	output logic in_ready,
	output logic out_valid,
	output cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.load   = in_valid && in_ready;
		cmd.commit = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/sbmq_datapath.sv
// Datapath with queue pointers, free list, link table and data store memories.
module sbmq_datapath
	import sbmq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic              req_type,
	input  logic [QID_W-1:0]  queue_id,
	input  logic [DATA_W-1:0] data_in,
	output logic [DATA_W-1:0] data_out,
	output logic [STAT_W-1:0] status
);

	logic [SLOT_W-1:0] head_q [QUEUES];
	logic [SLOT_W-1:0] tail_q [QUEUES];
	logic [QUEUES-1:0] nonempty_q;
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] fill_q;

	logic [LINK_W-1:0] link_mem [SLOTS];
	logic [DATA_W-1:0] data_mem [SLOTS];
	logic [LINK_W-1:0] link_rd_q;
	logic [DATA_W-1:0] data_rd_q;

	logic              req_type_s1;
	logic [QID_W-1:0]  qid_s1;
	logic [DATA_W-1:0] data_s1;

	logic [DATA_W-1:0] data_out_q;
	logic [STAT_W-1:0] status_q;

	logic              in_q_ok;
	logic [QIDX_W-1:0] in_qidx;
	logic [SLOT_W-1:0] rd_addr;

	logic              q_ok;
	logic [QIDX_W-1:0] qidx;
	logic              enq_ok;
	logic              deq_ok;
	logic [SLOT_W-1:0] free_slot;
	logic [SLOT_W-1:0] head_slot;
	logic [SLOT_W-1:0] tail_slot;
	logic              last_word;
	logic [LINK_W-1:0] next_free;
	logic              link_we;
	logic [SLOT_W-1:0] link_wr_addr;
	logic [LINK_W-1:0] link_wr_data;

	// The read address is set by the request as it is accepted.
	always_comb begin
		in_q_ok = int'(queue_id) < QUEUES;
		in_qidx = QIDX_W'(queue_id);
		if (req_type == REQ_ENQ) begin
			rd_addr = free_head_q[SLOT_W-1:0];
		end else begin
			rd_addr = in_q_ok ? head_q[in_qidx] : '0;
		end
	end

	always_comb begin
		q_ok      = int'(qid_s1) < QUEUES;
		qidx      = QIDX_W'(qid_s1);
		free_slot = free_head_q[SLOT_W-1:0];
		head_slot = q_ok ? head_q[qidx] : '0;
		tail_slot = q_ok ? tail_q[qidx] : '0;
		enq_ok    = (req_type_s1 == REQ_ENQ) && q_ok && (free_head_q < NULL_LINK);
		deq_ok    = (req_type_s1 == REQ_DEQ) && q_ok && nonempty_q[qidx];
		// A queue holding one word has equal head and tail.
		last_word = (head_slot == tail_slot);
		// A slot not yet handed out since reset still links to its successor.
		if (free_head_q == fill_q) begin
			next_free = free_head_q + LINK_W'(1);
		end else begin
			next_free = link_rd_q;
		end
		link_we      = 1'b0;
		link_wr_addr = tail_slot;
		link_wr_data = LINK_W'(free_slot);
		if (cmd.commit && enq_ok && nonempty_q[qidx]) begin
			link_we = 1'b1;
		end else if (cmd.commit && deq_ok) begin
			link_we      = 1'b1;
			link_wr_addr = head_slot;
			link_wr_data = free_head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			link_rd_q   <= link_mem[rd_addr];
			data_rd_q   <= data_mem[rd_addr];
			req_type_s1 <= req_type;
			qid_s1      <= queue_id;
			data_s1     <= data_in;
		end
		if (link_we) link_mem[link_wr_addr] <= link_wr_data;
		if (cmd.commit && enq_ok) data_mem[free_slot] <= data_s1;
		if (cmd.commit) begin
			if (deq_ok) begin
				data_out_q <= data_rd_q;
				status_q   <= STATUS_OK;
			end else if (enq_ok) begin
				data_out_q <= '0;
				status_q   <= STATUS_OK;
			end else begin
				data_out_q <= '0;
				status_q   <= (req_type_s1 == REQ_ENQ) ? STATUS_OVERFLOW : STATUS_UNDERFLOW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			nonempty_q  <= '0;
			free_head_q <= '0;
			fill_q      <= '0;
		end else if (cmd.commit) begin
			if (enq_ok) begin
				free_head_q <= next_free;
				if (free_head_q == fill_q) fill_q <= fill_q + LINK_W'(1);
				if (!nonempty_q[qidx]) begin
					head_q[qidx]     <= free_slot;
					nonempty_q[qidx] <= 1'b1;
				end
				tail_q[qidx] <= free_slot;
			end else if (deq_ok) begin
				if (last_word) begin
					nonempty_q[qidx] <= 1'b0;
				end else begin
					head_q[qidx] <= link_rd_q[SLOT_W-1:0];
				end
				free_head_q <= LINK_W'(head_slot);
			end
		end
	end

	assign data_out = data_out_q;
	assign status   = status_q;

endmodule

// File: hdl/shared_buffer_multi_queue_core.sv
// Four FIFO queues sharing one sixteen-word store through linked lists and a free list.
// Each request runs in two steps: the accept edge reads the link table and the data
// store at the slot the request addresses (free-list head or queue head), and the commit
// edge writes the pointers, link and data and loads the result register. A new request
// is accepted only after the previous one has committed; a result waiting in the output
// register holds back the commit of the following request.
// No clearing pass runs after reset: slots not yet handed out are tracked by a fill
// count, so requests are taken as soon as reset is released.
`include "shared_buffer_multi_queue_core_macros.svh"

module shared_buffer_multi_queue_core
	import sbmq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // [31:0] data_in
	input  logic [2:0]        s_tuser,  // [0] req_type, [2:1] queue_id
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // [31:0] data_out
	output logic [STAT_W-1:0] m_tuser   // [1:0] status
);

	cmd_t cmd;

	sbmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd)
	);

	sbmq_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_type (s_tuser[0]),
		.queue_id (s_tuser[2:1]),
		.data_in  (s_tdata),
		.data_out (m_tdata),
		.status   (m_tuser)
	);

	// A commit always leaves a result waiting for the consumer.
	`SBMQ_ASSERT_NEXT(a_commit_result, cmd.commit, m_tvalid)
	// Only one request is in flight between accept and commit.
	`SBMQ_ASSERT_NEXT(a_one_in_flight, cmd.load, !s_tready)
	// Failed requests return a zero word.
	`SBMQ_ASSERT_IMPL(a_fail_zero, m_tvalid && (m_tuser != STATUS_OK), m_tdata == '0)
	// Status carries only the three defined codes.
	`SBMQ_ASSERT_IMPL(a_status_code, m_tvalid, (m_tuser == STATUS_OK) || (m_tuser == STATUS_OVERFLOW) || (m_tuser == STATUS_UNDERFLOW))

endmodule
